[hdl/hcs_pkg.sv]
`default_nettype none
package hcs_pkg;

  localparam int AGE_BITS = 20;

  typedef logic [AGE_BITS-1:0] age_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PREHEAT = 3'd1,
    PH_COOK    = 3'd2,
    PH_DONE    = 3'd3,
    PH_ERROR   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    FLT_NONE     = 3'd0,
    FLT_OVERTEMP = 3'd1,
    FLT_TIMEOUT  = 3'd2,
    FLT_ESTOP    = 3'd3,
    FLT_HEATER   = 3'd4
  } fault_t;

  localparam logic [2:0] CMD_BEGIN = 3'd1;
  localparam logic [2:0] CMD_HALT  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_ABORT = 3'd4;

  localparam logic [1:0] REG_SENSOR_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_HEAT_RISE      = 2'd1;
  localparam logic [1:0] REG_DONE_RETURN    = 2'd2;

  localparam logic [15:0] SENSOR_TIMEOUT_RST = 16'd30;
  localparam logic [15:0] HEAT_RISE_RST      = 16'd1200;
  localparam logic [15:0] DONE_RETURN_RST    = 16'd600;

  // temperatures in tenths of a degree
  typedef struct packed {
    logic [10:0]        preheat;
    logic [10:0]        cook;
    logic signed [11:0] preheat_low;
    logic signed [11:0] cook_low;
    logic signed [11:0] cutoff;
    logic [15:0]        cook_periods;
    logic [6:0]         duty;
  } prof_t;

  typedef struct packed {
    phase_t             state;
    fault_t             fault;
    logic signed [11:0] temp;
    logic               heat_cmd_valid;
    logic               heat_enable;
    logic [10:0]        heat_setpoint;
    logic               motor_cmd_valid;
    logic [6:0]         motor_duty;
    logic               motor_brake;
  } res_t;

  function automatic prof_t prof_get(input logic delicate);
    prof_t p;
    if (delicate) begin
      p.preheat      = 11'd450;
      p.cook         = 11'd600;
      p.preheat_low  = 12'sd440;
      p.cook_low     = 12'sd590;
      p.cutoff       = 12'sd750;
      p.cook_periods = 16'd12000;
      p.duty         = 7'd40;
    end else begin
      p.preheat      = 11'd600;
      p.cook         = 11'd800;
      p.preheat_low  = 12'sd590;
      p.cook_low     = 12'sd790;
      p.cutoff       = 12'sd950;
      p.cook_periods = 16'd18000;
      p.duty         = 7'd60;
    end
    return p;
  endfunction

  function automatic age_t age_inc(input age_t a);
    return (a == '1) ? a : a + age_t'(1);
  endfunction

endpackage
`default_nettype wire

[hdl/heater_cycle_sequencer_unit.sv]
// a result is registered into the output register, or into the skid when the output register is held
// throughput: one item per cycle while the skid is empty; a two-entry output stage (register plus skid)
// lets an item be accepted while the previous result is still waiting
// reset (rst_n low, synchronous): phase idle with its entry pending, no fault,
// held temperature and all age counters zero, registers back to 30, 1200 and 600
`default_nettype none
module heater_cycle_sequencer_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_reading_valid,
  input  wire logic signed [11:0] in_reading_temp,
  input  wire logic [2:0]         in_command,
  input  wire logic [7:0]         in_profile_select,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_state_out,
  output logic [2:0]              out_fault_out,
  output logic signed [11:0]      out_temp_out,
  output logic                    out_heat_cmd_valid,
  output logic                    out_heat_enable,
  output logic [10:0]             out_heat_setpoint,
  output logic                    out_motor_cmd_valid,
  output logic [6:0]              out_motor_duty,
  output logic                    out_motor_brake
);
  import hcs_pkg::*;

  logic [15:0]        sensor_timeout_r, heat_rise_r, done_return_r;

  phase_t             phase_r, phase_nxt;
  logic               pend_r, pend_nxt;
  fault_t             fault_r, fault_nxt;
  logic               prof_r, prof_nxt;
  logic signed [11:0] temp_r, temp_nxt;
  age_t               read_age_r, read_age_nxt;
  logic               below_r, below_nxt;
  age_t               below_age_r, below_age_nxt;
  age_t               cook_age_r, cook_age_nxt;
  age_t               done_age_r, done_age_nxt;

  res_t               out_r, skid_r, res;
  logic               out_valid_r, skid_valid_r;

  logic               accept, out_take, estop;
  phase_t             ph_e;
  logic               pend_e;
  fault_t             fault_e;
  prof_t              prof;
  age_t               read_age_e, below_age_e, cook_age_e, done_age_e;
  logic               below_e;

  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  // emergency stop acts before the entry actions of this period
  assign estop   = (in_command == CMD_ABORT);
  assign ph_e    = estop ? PH_ERROR : phase_r;
  assign pend_e  = pend_r || (estop && (phase_r != PH_ERROR));
  assign fault_e = estop ? FLT_ESTOP : fault_r;
  assign prof    = prof_get(prof_r);

  // counters after the time base tick and the entry actions
  always_comb begin
    temp_nxt    = in_reading_valid ? in_reading_temp : temp_r;
    read_age_e  = in_reading_valid ? '0 : age_inc(read_age_r);
    below_age_e = age_inc(below_age_r);
    cook_age_e  = age_inc(cook_age_r);
    done_age_e  = age_inc(done_age_r);
    below_e     = below_r;
    if (pend_e) begin
      unique case (ph_e)
        PH_PREHEAT: begin
          read_age_e = '0;
          below_e    = 1'b0;
        end
        PH_COOK: begin
          cook_age_e = '0;
          below_e    = 1'b0;
        end
        PH_DONE:  done_age_e = '0;
        default:  ;
      endcase
    end
  end

  // next phase and fault checks
  always_comb begin
    logic               fault_hit;
    logic signed [11:0] low;
    phase_nxt     = ph_e;
    pend_nxt      = 1'b0;
    fault_nxt     = fault_e;
    prof_nxt      = prof_r;
    read_age_nxt  = read_age_e;
    below_nxt     = below_e;
    below_age_nxt = below_age_e;
    cook_age_nxt  = cook_age_e;
    done_age_nxt  = done_age_e;
    fault_hit     = 1'b0;
    low           = (ph_e == PH_COOK) ? prof.cook_low : prof.preheat_low;
    unique case (ph_e)
      PH_IDLE: begin
        if (in_command == CMD_BEGIN) begin
          prof_nxt  = (in_profile_select == 8'd1);
          fault_nxt = FLT_NONE;
          phase_nxt = PH_PREHEAT;
          pend_nxt  = 1'b1;
        end
      end
      PH_PREHEAT, PH_COOK: begin
        priority if (read_age_e > AGE_BITS'(sensor_timeout_r)) begin
          fault_nxt = FLT_TIMEOUT;
          fault_hit = 1'b1;
        end else if (temp_nxt > prof.cutoff) begin
          fault_nxt = FLT_OVERTEMP;
          fault_hit = 1'b1;
        end else if (temp_nxt < low) begin
          if (!below_e) begin
            below_nxt     = 1'b1;
            below_age_nxt = '0;
          end else if (below_age_e > AGE_BITS'(heat_rise_r)) begin
            fault_nxt = FLT_HEATER;
            fault_hit = 1'b1;
          end
        end else begin
          below_nxt = 1'b0;
        end
        if (fault_hit) begin
          phase_nxt = PH_ERROR;
          pend_nxt  = 1'b1;
        end else if (in_command == CMD_HALT) begin
          phase_nxt = PH_IDLE;
          pend_nxt  = 1'b1;
        end else if (ph_e == PH_PREHEAT) begin
          if (temp_nxt >= $signed({1'b0, prof.preheat})) begin
            phase_nxt = PH_COOK;
            pend_nxt  = 1'b1;
          end
        end else if (cook_age_e >= AGE_BITS'(prof.cook_periods)) begin
          phase_nxt = PH_DONE;
          pend_nxt  = 1'b1;
        end
      end
      PH_DONE: begin
        if ((in_command == CMD_HALT) || (done_age_e >= AGE_BITS'(done_return_r))) begin
          phase_nxt = PH_IDLE;
          pend_nxt  = 1'b1;
        end
      end
      PH_ERROR: begin
        if (in_command == CMD_CLEAR) begin
          fault_nxt = FLT_NONE;
          phase_nxt = PH_IDLE;
          pend_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // heater and motor commands, issued once on the period of a phase entry
  always_comb begin
    res                 = '0;
    res.state           = phase_nxt;
    res.fault           = fault_nxt;
    res.temp            = temp_nxt;
    res.heat_cmd_valid  = pend_e;
    res.motor_cmd_valid = pend_e;
    if (pend_e) begin
      unique case (ph_e)
        PH_PREHEAT: begin
          res.heat_enable   = 1'b1;
          res.heat_setpoint = prof.preheat;
        end
        PH_COOK: begin
          res.heat_enable   = 1'b1;
          res.heat_setpoint = prof.cook;
          res.motor_duty    = prof.duty;
        end
        PH_ERROR: res.motor_brake = 1'b1;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_timeout_r <= SENSOR_TIMEOUT_RST;
      heat_rise_r      <= HEAT_RISE_RST;
      done_return_r    <= DONE_RETURN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSOR_TIMEOUT: sensor_timeout_r <= cfg_data;
        REG_HEAT_RISE:      heat_rise_r      <= cfg_data;
        REG_DONE_RETURN:    done_return_r    <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pend_r      <= 1'b1;
      fault_r     <= FLT_NONE;
      prof_r      <= 1'b0;
      temp_r      <= '0;
      read_age_r  <= '0;
      below_r     <= 1'b0;
      below_age_r <= '0;
      cook_age_r  <= '0;
      done_age_r  <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      fault_r     <= fault_nxt;
      prof_r      <= prof_nxt;
      temp_r      <= temp_nxt;
      read_age_r  <= read_age_nxt;
      below_r     <= below_nxt;
      below_age_r <= below_age_nxt;
      cook_age_r  <= cook_age_nxt;
      done_age_r  <= done_age_nxt;
    end
  end

  // output register with skid; the skid always holds the newer item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_state_out       = out_r.state;
  assign out_fault_out       = out_r.fault;
  assign out_temp_out        = out_r.temp;
  assign out_heat_cmd_valid  = out_r.heat_cmd_valid;
  assign out_heat_enable     = out_r.heat_enable;
  assign out_heat_setpoint   = out_r.heat_setpoint;
  assign out_motor_cmd_valid = out_r.motor_cmd_valid;
  assign out_motor_duty      = out_r.motor_duty;
  assign out_motor_brake     = out_r.motor_brake;

  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output register is empty");

  a_idle_no_fault : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (fault_r == FLT_NONE))
    else $error("fault latched while idle");

  a_error_has_fault : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERROR) |-> (fault_r != FLT_NONE))
    else $error("error phase without a fault code");

  a_estop_takes_error : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_command == CMD_ABORT)) |=>
      ((phase_r == PH_ERROR) && (fault_r == FLT_ESTOP)))
    else $error("emergency stop did not reach error");

  a_heat_needs_cmd : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.heat_enable || out_r.motor_brake)) |->
      (out_r.heat_cmd_valid && out_r.motor_cmd_valid))
    else $error("heater or brake set without a command");

endmodule
`default_nettype wire

[dv/heater_cycle_sequencer_unit_tb.sv]
module heater_cycle_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcs_pkg::*;

  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [7:0] SEL_STANDARD = 8'd0;
  localparam logic [7:0] SEL_DELICATE = 8'd1;
  localparam int TEMP_MIN = -400;
  localparam int TEMP_MAX = 2000;
  localparam int CYCLE_LIMIT = 500000;
  localparam longint unsigned AGE_TOP = (64'd1 << AGE_BITS) - 64'd1;

  typedef struct {
    logic               rv;
    logic signed [11:0] temp;
    logic [2:0]         cmd;
    logic [7:0]         sel;
  } period_t;

  typedef struct {
    int          preheat;
    int          cook;
    int          cutoff;
    int unsigned periods;
    int unsigned duty;
  } recipe_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_SENSOR_TIMEOUT;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_reading_valid = 1'b0;
  logic signed [11:0] in_reading_temp = '0;
  logic [2:0]         in_command = CMD_NONE;
  logic [7:0]         in_profile_select = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_state_out;
  logic [2:0]         out_fault_out;
  logic signed [11:0] out_temp_out;
  logic               out_heat_cmd_valid;
  logic               out_heat_enable;
  logic [10:0]        out_heat_setpoint;
  logic               out_motor_cmd_valid;
  logic [6:0]         out_motor_duty;
  logic               out_motor_brake;

  heater_cycle_sequencer_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_reading_valid    (in_reading_valid),
    .in_reading_temp     (in_reading_temp),
    .in_command          (in_command),
    .in_profile_select   (in_profile_select),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_state_out       (out_state_out),
    .out_fault_out       (out_fault_out),
    .out_temp_out        (out_temp_out),
    .out_heat_cmd_valid  (out_heat_cmd_valid),
    .out_heat_enable     (out_heat_enable),
    .out_heat_setpoint   (out_heat_setpoint),
    .out_motor_cmd_valid (out_motor_cmd_valid),
    .out_motor_duty      (out_motor_duty),
    .out_motor_brake     (out_motor_brake)
  );

  always #1 clk = ~clk;

  period_t period_q[$];
  res_t    status_q[$];

  int  cycle_cnt = 0;
  int  pushed = 0;
  int  accepted_cnt = 0;
  int  results_cnt = 0;
  int  mismatches = 0;
  int  entries[5];
  int  fault_hits[5];
  bit  in_taken = 1'b0;
  bit  calm;

  // idling and output stalls switch off for a long stretch, periodically
  assign calm = (cycle_cnt % 20000) >= 15000;

  // sequencer state as predicted
  phase_t             ph = PH_IDLE;
  bit                 entry_due = 1'b1;
  fault_t             flt = FLT_NONE;
  bit                 prof_del = 1'b0;
  logic signed [11:0] temp_held = '0;
  longint unsigned    rd_age = 0;
  longint unsigned    low_age = 0;
  longint unsigned    ck_age = 0;
  longint unsigned    dn_age = 0;
  bit                 low_run = 1'b0;
  int unsigned        reg_timeout = SENSOR_TIMEOUT_RST;
  int unsigned        reg_rise = HEAT_RISE_RST;
  int unsigned        reg_done = DONE_RETURN_RST;

  function automatic recipe_t recipe(bit delicate);
    recipe_t r;
    if (delicate) begin
      r.preheat = 450;
      r.cook    = 600;
      r.cutoff  = 750;
      r.periods = 12000;
      r.duty    = 40;
    end else begin
      r.preheat = 600;
      r.cook    = 800;
      r.cutoff  = 950;
      r.periods = 18000;
      r.duty    = 60;
    end
    return r;
  endfunction

  function automatic longint unsigned bump(longint unsigned a);
    return (a >= AGE_TOP) ? AGE_TOP : a + 1;
  endfunction

  function automatic void move_to(phase_t nx);
    if (nx != ph) begin
      ph = nx;
      entry_due = 1'b1;
    end
  endfunction

  // timeout, overtemp and heater-fail checks of preheat and cook
  function automatic bit trip_check(recipe_t r, int target);
    int held;
    held = temp_held;
    if (rd_age > reg_timeout) begin
      flt = FLT_TIMEOUT;
      move_to(PH_ERROR);
      return 1'b1;
    end
    if (held > r.cutoff) begin
      flt = FLT_OVERTEMP;
      move_to(PH_ERROR);
      return 1'b1;
    end
    if (held < target - 10) begin
      if (!low_run) begin
        low_run = 1'b1;
        low_age = 0;
      end else if (low_age > reg_rise) begin
        flt = FLT_HEATER;
        move_to(PH_ERROR);
        return 1'b1;
      end
    end else begin
      low_run = 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic res_t advance_period(period_t p);
    res_t    o;
    recipe_t r;
    o = '0;
    rd_age = bump(rd_age);
    low_age = bump(low_age);
    ck_age = bump(ck_age);
    dn_age = bump(dn_age);
    if (p.rv) begin
      temp_held = p.temp;
      rd_age = 0;
    end
    if (p.cmd == CMD_ABORT) begin
      flt = FLT_ESTOP;
      move_to(PH_ERROR);
    end
    r = recipe(prof_del);
    if (entry_due) begin
      entry_due = 1'b0;
      o.heat_cmd_valid = 1'b1;
      o.motor_cmd_valid = 1'b1;
      entries[int'(ph)]++;
      case (ph)
        PH_PREHEAT: begin
          rd_age = 0;
          low_run = 1'b0;
          o.heat_enable = 1'b1;
          o.heat_setpoint = 11'(r.preheat);
        end
        PH_COOK: begin
          ck_age = 0;
          low_run = 1'b0;
          o.heat_enable = 1'b1;
          o.heat_setpoint = 11'(r.cook);
          o.motor_duty = 7'(r.duty);
        end
        PH_DONE: begin
          dn_age = 0;
        end
        PH_ERROR: begin
          o.motor_brake = 1'b1;
          fault_hits[int'(flt)]++;
        end
        default: begin
        end
      endcase
    end
    case (ph)
      PH_IDLE: begin
        if (p.cmd == CMD_BEGIN) begin
          prof_del = (p.sel == SEL_DELICATE);
          flt = FLT_NONE;
          move_to(PH_PREHEAT);
        end
      end
      PH_PREHEAT: begin
        if (!trip_check(r, r.preheat)) begin
          if (p.cmd == CMD_HALT) move_to(PH_IDLE);
          else if (temp_held >= r.preheat) move_to(PH_COOK);
        end
      end
      PH_COOK: begin
        if (!trip_check(r, r.cook)) begin
          if (p.cmd == CMD_HALT) move_to(PH_IDLE);
          else if (ck_age >= r.periods) move_to(PH_DONE);
        end
      end
      PH_DONE: begin
        if (p.cmd == CMD_HALT || dn_age >= reg_done) move_to(PH_IDLE);
      end
      default: begin
        if (p.cmd == CMD_CLEAR) begin
          flt = FLT_NONE;
          move_to(PH_IDLE);
        end
      end
    endcase
    o.state = ph;
    o.fault = flt;
    o.temp = temp_held;
    return o;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at result %0d: %s got %0d, expected %0d",
               results_cnt, what, got, want);
  endtask

  task automatic check_status(res_t want);
    if (out_state_out !== want.state) flag_mismatch("state", out_state_out, want.state);
    if (out_fault_out !== want.fault) flag_mismatch("fault", out_fault_out, want.fault);
    if (out_temp_out !== want.temp)
      flag_mismatch("temp", out_temp_out, $signed(want.temp));
    if (out_heat_cmd_valid !== want.heat_cmd_valid)
      flag_mismatch("heat_cmd_valid", out_heat_cmd_valid, want.heat_cmd_valid);
    if (out_heat_enable !== want.heat_enable)
      flag_mismatch("heat_enable", out_heat_enable, want.heat_enable);
    if (out_heat_setpoint !== want.heat_setpoint)
      flag_mismatch("heat_setpoint", out_heat_setpoint, want.heat_setpoint);
    if (out_motor_cmd_valid !== want.motor_cmd_valid)
      flag_mismatch("motor_cmd_valid", out_motor_cmd_valid, want.motor_cmd_valid);
    if (out_motor_duty !== want.motor_duty)
      flag_mismatch("motor_duty", out_motor_duty, want.motor_duty);
    if (out_motor_brake !== want.motor_brake)
      flag_mismatch("motor_brake", out_motor_brake, want.motor_brake);
  endtask

  // checker and predictor: results first, since a result never belongs to this edge's item
  always @(posedge clk) begin : watch
    res_t    want;
    period_t seen;
    if (rst_n) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("run stopped at cycle limit with %0d results outstanding", status_q.size());
        $display("Simulation FAILED");
        $finish;
      end else begin
        if (out_valid && !out_stall) begin
          if (status_q.size() == 0) begin
            flag_mismatch("result with nothing expected, state", out_state_out, -1);
          end else begin
            want = status_q.pop_front();
            check_status(want);
          end
          results_cnt++;
        end
        if (in_valid && !in_stall) begin
          seen.rv = in_reading_valid;
          seen.temp = in_reading_temp;
          seen.cmd = in_command;
          seen.sel = in_profile_select;
          status_q.push_back(advance_period(seen));
          accepted_cnt++;
          in_taken = 1'b1;
        end
      end
    end
  end

  always @(negedge clk) begin : drive
    period_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (period_q.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
        nxt = period_q.pop_front();
        in_valid <= 1'b1;
        in_reading_valid <= nxt.rv;
        in_reading_temp <= nxt.temp;
        in_command <= nxt.cmd;
        in_profile_select <= nxt.sel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 23);
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [7:0] rnd_sel();
    return 8'($urandom_range(255));
  endfunction

  // mostly no command; commands that leave the phase only when allowed
  function automatic logic [2:0] side_cmd(bit may_break);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return CMD_NONE;
    if (r < 92) return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    if (r < 95) return CMD_BEGIN;
    if (r < 98 || !may_break) return CMD_CLEAR;
    return $urandom_range(1) ? CMD_HALT : CMD_ABORT;
  endfunction

  function automatic int near_cook(recipe_t r);
    int unsigned k;
    k = $urandom_range(9);
    if (k < 7) return pick(r.cook - 10, r.cutoff);
    if (k == 7) return $urandom_range(1) ? r.cook - 10 : r.cook - 11;
    if (k == 8) return r.cutoff;
    return pick(r.cook - 60, r.cook - 11);
  endfunction

  task automatic queue_period(logic rv, int temp, logic [2:0] cmd, logic [7:0] sel);
    period_t p;
    p.rv = rv;
    p.temp = 12'(temp);
    p.cmd = cmd;
    p.sel = sel;
    period_q.push_back(p);
    pushed++;
  endtask

  task automatic queue_noise();
    queue_period(chance(50), pick(TEMP_MIN, TEMP_MAX), 3'($urandom_range(7)), rnd_sel());
  endtask

  // one way to leave preheat or cook abnormally, or none
  task automatic upset(int target, int cutoff, output bit ended);
    int k;
    ended = 1'b1;
    case ($urandom_range(11))
      0: begin
        queue_period(chance(50), pick(target - 10, cutoff), CMD_ABORT, rnd_sel());
      end
      1: begin
        queue_period(chance(50), pick(target - 10, cutoff), CMD_HALT, rnd_sel());
      end
      2: begin
        queue_period(1'b1, chance(50) ? cutoff + 1 : pick(cutoff + 1, TEMP_MAX),
                     CMD_NONE, rnd_sel());
      end
      3: begin
        if (reg_timeout < 100) begin
          for (k = 0; k <= reg_timeout; k++)
            queue_period(1'b0, pick(TEMP_MIN, TEMP_MAX), CMD_NONE, rnd_sel());
        end else begin
          ended = 1'b0;
        end
      end
      4: begin
        if (reg_rise < 100) begin
          for (k = 0; k < reg_rise + 3; k++)
            queue_period(1'b1, pick(TEMP_MIN, target - 11), CMD_NONE, rnd_sel());
        end else begin
          ended = 1'b0;
        end
      end
      default: begin
        ended = 1'b0;
      end
    endcase
  endtask

  task automatic queue_session();
    logic [7:0] sel;
    recipe_t    r;
    int         k;
    int         n;
    bit         ended;
    repeat ($urandom_range(2)) queue_noise();
    case ($urandom_range(3))
      0, 1: sel = SEL_DELICATE;
      2: sel = SEL_STANDARD;
      default: sel = rnd_sel();
    endcase
    r = recipe(sel == SEL_DELICATE);
    queue_period(1'b1, pick(TEMP_MIN, r.preheat - 11), CMD_BEGIN, sel);
    n = $urandom_range(1, 10);
    for (k = 0; k < n; k++)
      queue_period(chance(90), pick(r.preheat - 120, r.preheat - 1), side_cmd(1'b1), rnd_sel());
    upset(r.preheat, r.cutoff, ended);
    if (!ended) begin
      queue_period(chance(85), pick(r.preheat, r.cutoff), side_cmd(1'b1), rnd_sel());
      n = $urandom_range(2, 40);
      for (k = 0; k < n; k++)
        queue_period(chance(90), near_cook(r), side_cmd(1'b1), rnd_sel());
      upset(r.cook, r.cutoff, ended);
      if (!ended) queue_period(chance(50), near_cook(r), CMD_HALT, rnd_sel());
    end
    // linger, then clear any fault
    repeat ($urandom_range(2))
      queue_period(chance(50), pick(TEMP_MIN, TEMP_MAX), side_cmd(1'b0), rnd_sel());
    queue_period(chance(50), pick(TEMP_MIN, TEMP_MAX), CMD_CLEAR, rnd_sel());
    queue_period(chance(50), pick(TEMP_MIN, TEMP_MAX), CMD_NONE, rnd_sel());
  endtask

  // a full cook that runs out its duration and reaches done
  task automatic queue_long_cook(bit delicate, bit hold_in_done);
    recipe_t r;
    int      k;
    r = recipe(delicate);
    queue_period(1'b1, r.preheat - 50, CMD_BEGIN, delicate ? SEL_DELICATE : SEL_STANDARD);
    queue_period(1'b1, r.preheat, CMD_NONE, rnd_sel());
    for (k = 0; k < r.periods + 2; k++)
      queue_period(1'b1, pick(r.cook - 10, r.cutoff), side_cmd(1'b0), rnd_sel());
    if (hold_in_done) begin
      repeat ($urandom_range(3, 30))
        queue_period(chance(50), pick(TEMP_MIN, TEMP_MAX), CMD_NONE, rnd_sel());
      queue_period(chance(50), pick(TEMP_MIN, TEMP_MAX),
                   $urandom_range(1) ? CMD_HALT : CMD_ABORT, rnd_sel());
      queue_period(1'b0, 0, CMD_CLEAR, rnd_sel());
    end else begin
      repeat (reg_done + 1)
        queue_period(chance(50), pick(TEMP_MIN, TEMP_MAX), CMD_NONE, rnd_sel());
    end
    queue_period(1'b0, 0, CMD_NONE, rnd_sel());
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SENSOR_TIMEOUT: reg_timeout = val;
      REG_HEAT_RISE: reg_rise = val;
      REG_DONE_RETURN: reg_done = val;
      default: begin
      end
    endcase
  endtask

  task automatic wait_quiet();
    while (period_q.size() != 0 || in_valid || status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_sessions(int count);
    int mark;
    mark = pushed;
    while (pushed - mark < count) queue_session();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed walk at reset settings
    queue_period(1'b0, 0, CMD_NONE, 8'd0);
    queue_period(1'b1, TEMP_MIN, CMD_SPARE_LO, 8'd0);
    queue_period(1'b1, TEMP_MAX, CMD_SPARE_HI, 8'd255);
    queue_period(1'b0, -1, CMD_HALT, SEL_DELICATE);
    queue_period(1'b0, 0, CMD_CLEAR, 8'd0);
    queue_period(1'b1, 0, CMD_BEGIN, 8'd2);
    queue_period(1'b1, 589, CMD_NONE, 8'd0);
    queue_period(1'b1, 590, CMD_NONE, 8'd0);
    queue_period(1'b1, 600, CMD_NONE, 8'd0);
    queue_period(1'b1, 950, CMD_NONE, 8'd0);
    queue_period(1'b1, 951, CMD_NONE, 8'd0);
    // estop while the error entry is still pending, then again in error
    queue_period(1'b0, 0, CMD_ABORT, 8'd0);
    queue_period(1'b0, 0, CMD_BEGIN, 8'd0);
    queue_period(1'b0, 0, CMD_ABORT, 8'd0);
    queue_period(1'b0, 0, CMD_CLEAR, 8'd0);
    queue_period(1'b0, 0, CMD_BEGIN, SEL_DELICATE);
    queue_period(1'b1, 440, CMD_NONE, 8'd0);
    queue_period(1'b1, 439, CMD_HALT, 8'd0);
    queue_period(1'b0, 0, CMD_BEGIN, SEL_DELICATE);
    queue_period(1'b1, 300, CMD_ABORT, 8'd0);
    queue_period(1'b0, 0, CMD_CLEAR, 8'd0);
    queue_period(1'b0, 0, CMD_NONE, 8'd0);
    wait_quiet();

    // tightest limits
    write_reg(REG_SENSOR_TIMEOUT, 16'd1);
    write_reg(REG_HEAT_RISE, 16'd1);
    write_reg(REG_DONE_RETURN, 16'd1);
    random_sessions(300);
    queue_long_cook(1'b1, 1'b0);
    wait_quiet();

    // loosest limits
    write_reg(REG_SENSOR_TIMEOUT, 16'hFFFF);
    write_reg(REG_HEAT_RISE, 16'hFFFF);
    write_reg(REG_DONE_RETURN, 16'hFFFF);
    random_sessions(300);
    queue_long_cook(1'b0, 1'b1);
    wait_quiet();

    // small random limits so timeouts and heater faults fire often
    write_reg(REG_SENSOR_TIMEOUT, 16'($urandom_range(2, 40)));
    write_reg(REG_HEAT_RISE, 16'($urandom_range(2, 60)));
    write_reg(REG_DONE_RETURN, 16'($urandom_range(2, 80)));
    random_sessions(400);
    queue_long_cook(1'b1, 1'b0);
    wait_quiet();

    if (status_q.size() != 0) flag_mismatch("results never delivered", 0, status_q.size());
    $display("covered %0d control periods and %0d results in %0d cycles",
             accepted_cnt, results_cnt, cycle_cnt);
    $display("entries idle %0d preheat %0d cook %0d done %0d error %0d; %s %0d %0d %0d %0d",
             entries[PH_IDLE], entries[PH_PREHEAT], entries[PH_COOK], entries[PH_DONE],
             entries[PH_ERROR], "faults overtemp/timeout/estop/heater",
             fault_hits[FLT_OVERTEMP], fault_hits[FLT_TIMEOUT], fault_hits[FLT_ESTOP],
             fault_hits[FLT_HEATER]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
